// ===== sv/dqe_pkg.sv =====
package dqe_pkg;

  localparam int DEPTH_DEF = 16;

  localparam int DATA_W   = 32;
  localparam int OP_W     = 3;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam logic [OP_W-1:0] OP_QUERY      = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;

endpackage

// ===== sv/dqe_ram.sv =====
module dqe_ram #(
  parameter int Depth = dqe_pkg::DEPTH_DEF,
  parameter int AddrW = $clog2(dqe_pkg::DEPTH_DEF),
  parameter int DataW = dqe_pkg::DATA_W
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);
  import dqe_pkg::*;

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/double_ended_queue_engine.sv =====
// double-ended queue on a ring memory of DEPTH words
// the result strobe is registered and comes in the cycle after the request is accepted
// throughput: one request per cycle, busy_o stays low; after a pop the new end
//   word is read through the single registered ram read port and forwarded
// reset: pointers, count and result strobe cleared, ram contents left as they are
// the receiver cannot stall, each result is shown for exactly one cycle
module double_ended_queue_engine #(
  parameter int DEPTH = dqe_pkg::DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [dqe_pkg::OP_W-1:0]            opcode_i,
  input  logic signed [dqe_pkg::DATA_W-1:0]   push_value_i,
  output logic                                result_valid_o,
  output logic signed [dqe_pkg::DATA_W-1:0]   popped_value_o,
  output logic [dqe_pkg::STATUS_W-1:0]        status_o,
  output logic signed [dqe_pkg::DATA_W-1:0]   front_value_o,
  output logic signed [dqe_pkg::DATA_W-1:0]   back_value_o,
  output logic [dqe_pkg::COUNT_W-1:0]         element_count_o,
  output logic                                is_empty_o
);
  import dqe_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  typedef enum logic [1:0] {
    FIX_NONE,
    FIX_FRONT,
    FIX_BACK
  } fix_e;

  function automatic logic [AW-1:0] slot_next(input logic [AW-1:0] i);
    return (i == LAST_SLOT) ? '0 : i + AW'(1);
  endfunction

  function automatic logic [AW-1:0] slot_prev(input logic [AW-1:0] i);
    return (i == '0) ? LAST_SLOT : i - AW'(1);
  endfunction

  logic [AW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CW-1:0] count_q, count_d;
  logic signed [DATA_W-1:0] front_q, front_d, back_q, back_d;
  fix_e fix_q, fix_d;
  logic valid_q, valid_d;
  logic signed [DATA_W-1:0] popped_q, popped_d;
  logic [STATUS_W-1:0] status_q, status_d;

  logic accept;
  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [DATA_W-1:0] rdata;
  logic signed [DATA_W-1:0] front_eff, back_eff;
  logic is_full, is_empty;

  dqe_ram #(
    .Depth (DEPTH),
    .AddrW (AW),
    .DataW (DATA_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (push_value_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign busy_o   = 1'b0;
  assign accept   = start_i && !busy_o;
  assign is_full  = (count_q == FULL_CNT);
  assign is_empty = (count_q == '0);

  // new end word after a pop arrives from the registered ram read in the next cycle
  assign front_eff = (fix_q == FIX_FRONT) ? $signed(rdata) : front_q;
  assign back_eff  = (fix_q == FIX_BACK)  ? $signed(rdata) : back_q;

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    front_d  = front_eff;
    back_d   = back_eff;
    fix_d    = FIX_NONE;
    valid_d  = accept;
    popped_d = '0;
    status_d = ST_OK;
    we       = 1'b0;
    waddr    = slot_prev(head_q);
    raddr    = slot_next(head_q);
    if (accept) begin
      case (opcode_i)
        OP_PUSH_FRONT: begin
          if (is_full) begin
            status_d = ST_OVERFLOW;
          end else begin
            we      = 1'b1;
            waddr   = slot_prev(head_q);
            head_d  = slot_prev(head_q);
            count_d = count_q + CW'(1);
            front_d = push_value_i;
            if (is_empty) begin
              back_d = push_value_i;
            end
          end
        end
        OP_PUSH_BACK: begin
          if (is_full) begin
            status_d = ST_OVERFLOW;
          end else begin
            we      = 1'b1;
            waddr   = tail_q;
            tail_d  = slot_next(tail_q);
            count_d = count_q + CW'(1);
            back_d  = push_value_i;
            if (is_empty) begin
              front_d = push_value_i;
            end
          end
        end
        OP_POP_FRONT: begin
          if (is_empty) begin
            status_d = ST_UNDERFLOW;
          end else begin
            popped_d = front_eff;
            head_d   = slot_next(head_q);
            raddr    = slot_next(head_q);
            count_d  = count_q - CW'(1);
            fix_d    = FIX_FRONT;
          end
        end
        OP_POP_BACK: begin
          if (is_empty) begin
            status_d = ST_UNDERFLOW;
          end else begin
            popped_d = back_eff;
            tail_d   = slot_prev(tail_q);
            raddr    = slot_prev(slot_prev(tail_q));
            count_d  = count_q - CW'(1);
            fix_d    = FIX_BACK;
          end
        end
        default: begin
          status_d = ST_OK;
        end
      endcase
    end else begin
      fix_d = fix_q;
      raddr = (fix_q == FIX_BACK) ? slot_prev(tail_q) : head_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      tail_q   <= '0;
      count_q  <= '0;
      fix_q    <= FIX_NONE;
      valid_q  <= 1'b0;
      front_q  <= '0;
      back_q   <= '0;
      popped_q <= '0;
      status_q <= ST_OK;
    end else begin
      head_q   <= head_d;
      tail_q   <= tail_d;
      count_q  <= count_d;
      fix_q    <= fix_d;
      valid_q  <= valid_d;
      front_q  <= front_d;
      back_q   <= back_d;
      popped_q <= popped_d;
      status_q <= status_d;
    end
  end

  assign result_valid_o  = valid_q;
  assign popped_value_o  = popped_q;
  assign status_o        = status_q;
  assign front_value_o   = is_empty ? '1 : front_eff;
  assign back_value_o    = is_empty ? '1 : back_eff;
  assign element_count_o = COUNT_W'(count_q);
  assign is_empty_o      = is_empty;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT)
    else $error("count exceeds depth");

  a_ptr_meet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 || count_q == FULL_CNT) |-> head_q == tail_q)
    else $error("head and tail disagree with count");

  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && status_q == ST_OVERFLOW) |-> is_full)
    else $error("overflow reported on a queue that is not full");

  a_underflow_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && status_q == ST_UNDERFLOW) |-> is_empty)
    else $error("underflow reported on a queue that is not empty");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !is_empty && (opcode_i == OP_POP_FRONT || opcode_i == OP_POP_BACK))
      |=> count_q == $past(count_q) - CW'(1))
    else $error("pop did not lower the count");

endmodule
